// File: rtl/assert_macros.svh
// Assertion macros of the angle tracker, included by its top level.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mat_pkg.sv
// Constants and types of the multi-turn angle tracker.
// No dependencies; used by the interfaces, the divider and the top level.
package mat_pkg;

  localparam int COUNT_BITS = 14;
  localparam int TIME_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DVD_W      = COUNT_BITS + FRAC_BITS;
  localparam int POS_W      = 48;
  localparam int TURN_W     = 32;
  localparam int VEL_W      = 31;
  localparam int VREG_W     = 32;
  localparam int OFS_W      = 32;

  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  localparam logic [VREG_W-1:0] VEL_POS_MAX = 32'h3FFF_FFFF;
  localparam logic [VREG_W-1:0] VEL_NEG_MAX = 32'h4000_0000;

  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [TIME_BITS-1:0]     tick_t;
  typedef logic [DVD_W-1:0]         dvd_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [TURN_W-1:0] turn_t;
  typedef logic signed [VEL_W-1:0]  vel_t;
  typedef logic signed [OFS_W-1:0]  ofs_t;

endpackage

// File: rtl/mat_if.sv
// Valid/ready channel interfaces of the angle tracker: sample input,
// result output and offset configuration. Depends on mat_pkg.
interface mat_in_if;
  import mat_pkg::*;
  logic   valid;
  logic   ready;
  count_t raw_count;
  tick_t  timestamp;
  modport source (output valid, output raw_count, output timestamp, input ready);
  modport sink   (input valid, input raw_count, input timestamp, output ready);
endinterface

interface mat_out_if;
  import mat_pkg::*;
  logic  valid;
  logic  ready;
  pos_t  position;
  turn_t turns;
  vel_t  velocity;
  logic  velocity_held;
  modport source (output valid, output position, output turns, output velocity,
                  output velocity_held, input ready);
  modport sink   (input valid, input position, input turns, input velocity,
                  input velocity_held, output ready);
endinterface

interface mat_cfg_if;
  import mat_pkg::*;
  logic valid;
  logic ready;
  ofs_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mat_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, DVD_W quotient bits in all.
// Depends on mat_pkg for the dividend and divisor widths.
module mat_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mat_pkg::dvd_t  dividend,
  input  mat_pkg::tick_t divisor,
  output logic          done,
  output mat_pkg::dvd_t  quotient
);
  import mat_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic                 run_r;
  logic [CNT_W-1:0]     cnt_r;
  dvd_t                 quo_r, quo_nxt;
  tick_t                rem_r, rem_nxt;
  tick_t                dsr_r;
  logic [TIME_BITS:0]   rem_sh;
  logic [TIME_BITS:0]   diff;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    diff    = rem_sh - {1'b0, dsr_r};
    fits    = !diff[TIME_BITS];
    rem_nxt = fits ? diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(DVD_W);
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r && cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = run_r && (cnt_r == '0);
  assign quotient = quo_r;

endmodule

// File: rtl/multiturn_angle_tracker.sv
// Multi-turn angle tracker: one transaction per sample, one result per sample.
// Depends on mat_pkg, the channel interfaces and the divider mat_div.
//
// Each sample carries a 14-bit absolute count and a tick timestamp. The block
// counts turns from quadrant crossings, reports position as turns times
// 2^14 plus count minus angle_offset, and a Q16 velocity: count difference
// divided by tick difference. A sample whose tick difference is zero skips
// the divider: it goes from S_IDLE straight to S_FIN, which writes its
// result to the output register once that register is free. Any other
// sample goes through the bit-serial divider, which yields one quotient
// bit per cycle over DVD_W = 30 bits, and passes from S_IDLE through S_DIV,
// until the divider is done, to S_FIN. One sample is in work at a time; the
// next sample is accepted as soon as the previous result sits in the output
// register, even if the sink has not taken it yet. angle_offset may be
// written whenever no sample is in work.
module multiturn_angle_tracker (
  input logic       clk,
  input logic       rst_n,
  mat_in_if.sink    in_ch,
  mat_out_if.source out_ch,
  mat_cfg_if.sink   cfg_ch
);
  import mat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]  state_r, state_nxt;

  // Tracker state visible to the next sample.
  count_t      last_count_r;
  turn_t       turns_r, turns_nxt;
  tick_t       last_time_r;
  logic [VREG_W-1:0] vel_reg_r;
  ofs_t        offset_r;

  // Per-sample work registers.
  logic        neg_r;
  logic        held_r;

  logic        out_valid_r;
  pos_t        position_r;
  turn_t       turns_out_r;
  vel_t        velocity_r;
  logic        held_out_r;

  logic        in_acc, out_free, fin_wr;
  count_t      count_in;
  tick_t       dt;
  logic        neg_in;
  count_t      mag;
  logic [1:0]  quad_prev, quad_cur;

  logic        div_start, div_done;
  dvd_t        quotient;

  logic [VREG_W-1:0] q_ext, q_sat, vel_new;
  pos_t        pos_base, pos_val;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign fin_wr       = (state_r == S_FIN) && out_free;

  // Accept side: quadrant crossing, tick difference and count magnitude.
  always_comb begin
    count_in  = in_ch.raw_count;
    quad_prev = last_count_r[COUNT_BITS-1 -: 2];
    quad_cur  = count_in[COUNT_BITS-1 -: 2];
    turns_nxt = turns_r;
    if (quad_prev == QUAD_FOURTH && quad_cur == QUAD_FIRST) begin
      turns_nxt = turns_r + turn_t'(1);
    end else if (quad_prev == QUAD_FIRST && quad_cur == QUAD_FOURTH) begin
      turns_nxt = turns_r - turn_t'(1);
    end
    dt        = in_ch.timestamp - last_time_r;
    neg_in    = count_in < last_count_r;
    mag       = neg_in ? (last_count_r - count_in) : (count_in - last_count_r);
    div_start = in_acc && (dt != '0);
  end

  mat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mag, FRAC_BITS'(0)}),
    .divisor  (dt),
    .done     (div_done),
    .quotient (quotient)
  );

  // Finish side: saturate and sign the quotient, assemble the position.
  always_comb begin
    q_ext    = VREG_W'(quotient);
    if (neg_r) begin
      q_sat   = (q_ext > VEL_NEG_MAX) ? VEL_NEG_MAX : q_ext;
      vel_new = '0 - q_sat;
    end else begin
      q_sat   = (q_ext > VEL_POS_MAX) ? VEL_POS_MAX : q_ext;
      vel_new = q_sat;
    end
    pos_base = (POS_W'(turns_r) << COUNT_BITS) | pos_t'(POS_W'(last_count_r));
    pos_val  = pos_base - POS_W'(offset_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (dt == '0) ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      last_count_r <= '0;
      turns_r      <= '0;
      last_time_r  <= '0;
      vel_reg_r    <= '0;
      offset_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        offset_r <= cfg_ch.data;
      end
      if (in_acc) begin
        last_count_r <= count_in;
        turns_r      <= turns_nxt;
        if (dt != '0) begin
          last_time_r <= in_ch.timestamp;
        end
      end
      if (fin_wr) begin
        out_valid_r <= 1'b1;
        if (!held_r) begin
          vel_reg_r <= vel_new;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r  <= neg_in;
      held_r <= (dt == '0);
    end
    if (fin_wr) begin
      position_r  <= pos_val;
      turns_out_r <= turns_r;
      velocity_r  <= held_r ? vel_t'(vel_reg_r[VEL_W-1:0]) : vel_t'(vel_new[VEL_W-1:0]);
      held_out_r  <= held_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = position_r;
  assign out_ch.turns         = turns_out_r;
  assign out_ch.velocity      = velocity_r;
  assign out_ch.velocity_held = held_out_r;

`include "assert_macros.svh"

  `ASSERT_HOLDS(a_div_done_in_div, div_done |-> state_r == S_DIV, "divider done outside S_DIV")
  `ASSERT_NEXT(a_held_skips_div, in_acc && dt == '0, state_r == S_FIN && held_r, "held in divider")
  `ASSERT_NEXT(a_turns_only_on_accept, !in_acc, $stable(turns_r), "turns moved idle")
  `ASSERT_HOLDS(a_result_from_fin, $rose(out_valid_r) |-> $past(state_r) == S_FIN, "no finish")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the multi-turn angle tracker: directed and random samples.
// A scoreboard class predicts each result. Depends on mat_pkg, the channel interfaces
// and multiturn_angle_tracker.
module tb;
  import mat_pkg::*;

  typedef struct {
    pos_t  position;
    turn_t turns;
    vel_t  velocity;
    logic  velocity_held;
  } tracker_result_t;

  class angle_scoreboard;
    ofs_t                angle_offset;
    count_t              last_count;
    turn_t               turn_counter;
    tick_t               last_tick;
    logic [VREG_W-1:0]   velocity_reg;
    tracker_result_t     expected_q[$];
    int                  fail_count;

    function new();
      angle_offset = '0;
      last_count   = '0;
      turn_counter = '0;
      last_tick    = '0;
      velocity_reg = '0;
      fail_count   = 0;
    endfunction

    function void load_offset(ofs_t value);
      angle_offset = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Predicts the result of one accepted sample and advances the tracker state.
    function void note_sample(count_t count, tick_t stamp);
      logic [1:0]      quad_prev;
      logic [1:0]      quad_now;
      tick_t           dt;
      logic [63:0]     mag;
      logic [63:0]     quo;
      logic            neg;
      longint          pos;
      tracker_result_t r;
      quad_prev = last_count[COUNT_BITS-1 -: 2];
      quad_now  = count[COUNT_BITS-1 -: 2];
      if (quad_prev == QUAD_FOURTH && quad_now == QUAD_FIRST) begin
        turn_counter = turn_counter + 1;
      end else if (quad_prev == QUAD_FIRST && quad_now == QUAD_FOURTH) begin
        turn_counter = turn_counter - 1;
      end
      dt = stamp - last_tick;
      r.velocity_held = (dt == '0);
      if (!r.velocity_held) begin
        // The count difference is taken as is, without correcting for the turn wrap.
        neg = count < last_count;
        mag = neg ? 64'(last_count) - 64'(count) : 64'(count) - 64'(last_count);
        quo = (mag << FRAC_BITS) / 64'(dt);
        if (neg) begin
          if (quo > 64'(VEL_NEG_MAX)) quo = 64'(VEL_NEG_MAX);
          velocity_reg = '0 - quo[VREG_W-1:0];
        end else begin
          if (quo > 64'(VEL_POS_MAX)) quo = 64'(VEL_POS_MAX);
          velocity_reg = quo[VREG_W-1:0];
        end
        last_tick = stamp;
      end
      last_count = count;
      pos = (longint'(turn_counter) <<< COUNT_BITS) + longint'(count)
            - longint'(angle_offset);
      r.position = pos[POS_W-1:0];
      r.turns    = turn_counter;
      r.velocity = velocity_reg[VEL_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(pos_t position, turn_t turns, vel_t velocity, logic held);
      tracker_result_t want;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR: result with none outstanding: pos=%0d turns=%0d vel=%0d held=%0b",
                   position, turns, velocity, held);
        end
        return;
      end
      want = expected_q.pop_front();
      if (position !== want.position || turns !== want.turns ||
          velocity !== want.velocity || held !== want.velocity_held) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("ERROR: expected pos=%0d turns=%0d vel=%0d held=%0b", want.position,
                   want.turns, want.velocity, want.velocity_held);
          $display("       actual   pos=%0d turns=%0d vel=%0d held=%0b", position, turns,
                   velocity, held);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic hold_active = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  // Simulated sensor used for the smooth-motion part of the random stimulus.
  count_t shaft_count = '0;
  tick_t  shaft_tick = '0;
  int     spin_dir = 1;

  angle_scoreboard sb = new();

  mat_in_if  in_ch();
  mat_out_if out_ch();
  mat_cfg_if cfg_ch();

  multiturn_angle_tracker i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.load_offset(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.raw_count, in_ch.timestamp);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.position, out_ch.turns, out_ch.velocity, out_ch.velocity_held);
      end
    end
  end

  task automatic send_sample(count_t count, tick_t stamp);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.raw_count <= count;
    in_ch.timestamp <= stamp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering samples until every predicted result has been taken.
  // The first edge lets the scoreboard note a transaction accepted just before.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offset(ofs_t value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic hold_receiver(int cycles);
    fork
      begin
        hold_active <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_active <= 1'b0;
      end
    join_none
  endtask

  // Mostly smooth rotation with occasional reversals, repeated ticks and time jumps;
  // one sample in five is fully random noise.
  task automatic send_motion(int n);
    int step;
    int pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 5) spin_dir = -spin_dir;
        step = ($urandom_range(99) < 10) ? $urandom_range(0, 16383)
                                         : $urandom_range(0, 1500);
        shaft_count = shaft_count + count_t'(step * spin_dir);
        pick = $urandom_range(99);
        if (pick < 10) begin
          shaft_tick = shaft_tick;
        end else if (pick < 15) begin
          shaft_tick = shaft_tick + tick_t'($urandom);
        end else begin
          shaft_tick = shaft_tick + tick_t'($urandom_range(1, 3000));
        end
      end else begin
        shaft_count = count_t'($urandom);
        shaft_tick  = tick_t'($urandom);
      end
      send_sample(shaft_count, shaft_tick);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.raw_count  <= '0;
    in_ch.timestamp  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First sample compares against the reset time and count, so it holds velocity.
    send_sample(14'h0000, 32'h0000_0000);
    send_sample(14'h3FFF, 32'h0000_0001);
    send_sample(14'h0000, 32'h0000_0002);
    send_sample(14'h0000, 32'h0000_0002);
    send_sample(14'h3000, 32'hFFFF_FFFF);
    // The tick counter wraps here.
    send_sample(14'h0FFF, 32'h0000_0004);
    send_sample(14'h1000, 32'h0000_0005);
    send_sample(14'h2000, 32'h8000_0000);
    send_sample(14'h2FFF, 32'h8000_0000);
    send_sample(14'h3FFF, 32'h8000_0001);
    send_sample(14'h1555, 32'h8000_0002);
    send_sample(14'h2AAA, 32'h5555_5555);
    send_sample(14'h3FFF, 32'hAAAA_AAAA);
    send_sample(14'h0000, 32'hAAAA_AAAB);
    send_sample(14'h3FFF, 32'hAAAA_AAAB);
    write_offset(32'sh7FFF_FFFF);
    send_sample(14'h0000, 32'hAAAA_AAAC);
    send_sample(14'h3FFF, 32'hAAAA_AAAD);
    write_offset(32'sh8000_0000);
    send_sample(14'h0000, 32'hFFFF_FFFF);
    send_sample(14'h2AAA, 32'h0000_0000);

    // Back-to-back traffic, with one long receiver hold-off so the block backs up.
    write_offset(ofs_t'($urandom));
    idle_pct  = 0;
    stall_pct = 0;
    send_motion(220);
    hold_receiver(400);
    send_motion(220);

    write_offset(32'sh0000_0000);
    idle_pct = 59;
    send_motion(220);
    drain_results();
    send_motion(220);

    write_offset(ofs_t'($urandom));
    idle_pct  = 0;
    stall_pct = 59;
    send_motion(440);

    write_offset(-32'sd1);
    idle_pct  = 23;
    stall_pct = 23;
    send_motion(440);

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mat_pkg.sv
rtl/mat_if.sv
rtl/mat_div.sv
rtl/multiturn_angle_tracker.sv
tb/tb.sv
